[hdl/vertex_to_raster_projection_core_defines.svh]
// Assertion macros used by the checker file of the projection core.
// No dependencies; the including module must declare clk and rst_n.
`ifndef VERTEX_TO_RASTER_PROJECTION_CORE_DEFINES_SVH
`define VERTEX_TO_RASTER_PROJECTION_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define VRP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrp check failed");

// Next-cycle implication, held off while reset is asserted
`define VRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrp check failed");

`endif

[hdl/vrp_pkg.sv]
// Shared widths, register indexes and limits of the vertex projection core.
// No dependencies; used by the core, the screen dividers and the raster maps.
package vrp_pkg;

    // Field and coefficient widths
    localparam int COORD_WIDTH    = 24;
    localparam int COEF_FRAC_BITS = 13;
    localparam int COEF_BITS      = 16;
    localparam int TRANS_BITS     = 21;
    localparam int ROT_W          = 3 * COEF_BITS;
    localparam int TRANS_W        = 3 * TRANS_BITS;
    localparam int CANVAS_W       = 16;
    localparam int IMG_W          = 13;
    localparam int RASTER_W       = 16;

    // Camera space: product of coefficient and coordinate, plus sum headroom
    localparam int PROD_W = COEF_BITS + COORD_WIDTH;
    localparam int CAM_W  = PROD_W + 2;

    // Screen divider: integer range limit and fraction bits of the quotient
    localparam int SCREEN_INT_BITS = 24;
    localparam int SCREEN_FRAC     = 16;
    localparam int SDIV_STEPS      = SCREEN_INT_BITS + SCREEN_FRAC;
    localparam int SDIV_R_W        = CAM_W + 1;
    localparam int SDIV_LAT        = SDIV_STEPS + 1;
    localparam int S_W             = SDIV_STEPS + 2;
    localparam logic [SDIV_STEPS:0] SCREEN_MAG_LIMIT = {1'b1, {SDIV_STEPS{1'b0}}};

    // Raster mapping: numerator, divisor (16 * canvas) and quotient widths
    localparam int T_W         = S_W + 1;
    localparam int N_W         = T_W + IMG_W + 1;
    localparam int RDIV_STEPS  = RASTER_W;
    localparam int RDIV_D_W    = CANVAS_W + 4;
    localparam int RDIV_R_W    = RDIV_D_W + 1;
    localparam int RMAP_LAT    = RDIV_STEPS + 3;

    // Products, camera sums, dividers, raster map, output register
    localparam int PIPE_LAT = 2 + SDIV_LAT + RMAP_LAT + 1;

    localparam logic signed [RASTER_W-1:0] RASTER_MAX = 16'sh7FFF;
    localparam logic signed [RASTER_W-1:0] RASTER_MIN = 16'sh8000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ROT_X      = 3'd0,
        REG_ROT_Y      = 3'd1,
        REG_ROT_Z      = 3'd2,
        REG_TRANS      = 3'd3,
        REG_CANVAS_W   = 3'd4,
        REG_CANVAS_H   = 3'd5,
        REG_IMAGE_W    = 3'd6,
        REG_IMAGE_H    = 3'd7
    } reg_index_t;

endpackage

[hdl/vertex_to_raster_projection_core.sv]
// Vertex to raster projection core. Accepts one world-space vertex per clock while
// the output is not stalled and returns one raster result per vertex, in order. The
// pipeline holds the two 40-stage screen dividers (one quotient bit per stage) and
// the two 16-stage raster dividers; a stall at the output freezes the whole pipeline,
// input side included, while a result leaving and a new vertex entering can share
// the same cycle. Configuration is written through a plain write port; the user must
// write it only while the pipeline is empty, as the block does not enforce this.
// Depends on vrp_pkg, vrp_screen_div and vrp_raster_map.
module vertex_to_raster_projection_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [62:0] cfg_wdata,
    // Vertex in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // world_x[23:0], world_y[47:24], world_z[71:48]
    // Raster out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // raster_x[15:0], raster_y[31:16]
    output logic [1:0]  m_axis_tuser    // depth_zero[0], saturated[1]
);

    localparam int LAT   = vrp_pkg::PIPE_LAT;
    localparam int ZLAST = LAT - 2;
    localparam int CW    = vrp_pkg::CAM_W;
    localparam int PW    = vrp_pkg::PROD_W;
    localparam int CB    = vrp_pkg::COEF_BITS;
    localparam int TB    = vrp_pkg::TRANS_BITS;
    localparam int XW    = vrp_pkg::COORD_WIDTH;

    // Configuration registers
    logic [vrp_pkg::ROT_W-1:0]    rot_reg [3];
    logic [vrp_pkg::TRANS_W-1:0]  trans_reg;
    logic [vrp_pkg::CANVAS_W-1:0] cw_reg;
    logic [vrp_pkg::CANVAS_W-1:0] ch_reg;
    logic [vrp_pkg::IMG_W-1:0]    iw_reg;
    logic [vrp_pkg::IMG_W-1:0]    ih_reg;

    // Pipeline control and data
    logic [LAT-1:0]         v_reg;
    logic [ZLAST:1]         z_reg;
    logic signed [PW-1:0]   prod_reg [3][3];
    logic signed [PW-1:0]   prod_next [3][3];
    logic signed [CW-1:0]   cam_reg [3];
    logic signed [CW-1:0]   cam_next [3];
    logic signed [CB-1:0]   coef_s [3][3];
    logic signed [XW-1:0]   wld_s [3];
    logic signed [TB-1:0]   trans_s [3];

    logic                   adv;
    logic [vrp_pkg::CANVAS_W-1:0] cw_eff;
    logic [vrp_pkg::CANVAS_W-1:0] ch_eff;
    logic signed [vrp_pkg::S_W-1:0]      sx;
    logic signed [vrp_pkg::S_W-1:0]      sy;
    logic signed [vrp_pkg::RASTER_W-1:0] rx;
    logic signed [vrp_pkg::RASTER_W-1:0] ry;
    logic                   sat_x;
    logic                   sat_y;

    logic signed [vrp_pkg::RASTER_W-1:0] rx_reg;
    logic signed [vrp_pkg::RASTER_W-1:0] ry_reg;
    logic                   zero_reg;
    logic                   sat_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= 48'd8192;
            rot_reg[1] <= 48'd8192 << 16;
            rot_reg[2] <= 48'd8192 << 32;
            trans_reg  <= '0;
            cw_reg     <= 16'd8192;
            ch_reg     <= 16'd8192;
            iw_reg     <= 13'd512;
            ih_reg     <= 13'd512;
        end
        else if (cfg_we)
        begin
            case (vrp_pkg::reg_index_t'(cfg_addr))
                vrp_pkg::REG_ROT_X:    rot_reg[0] <= cfg_wdata[vrp_pkg::ROT_W-1:0];
                vrp_pkg::REG_ROT_Y:    rot_reg[1] <= cfg_wdata[vrp_pkg::ROT_W-1:0];
                vrp_pkg::REG_ROT_Z:    rot_reg[2] <= cfg_wdata[vrp_pkg::ROT_W-1:0];
                vrp_pkg::REG_TRANS:    trans_reg  <= cfg_wdata[vrp_pkg::TRANS_W-1:0];
                vrp_pkg::REG_CANVAS_W: cw_reg     <= cfg_wdata[vrp_pkg::CANVAS_W-1:0];
                vrp_pkg::REG_CANVAS_H: ch_reg     <= cfg_wdata[vrp_pkg::CANVAS_W-1:0];
                vrp_pkg::REG_IMAGE_W:  iw_reg     <= cfg_wdata[vrp_pkg::IMG_W-1:0];
                vrp_pkg::REG_IMAGE_H:  ih_reg     <= cfg_wdata[vrp_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the result register is free or being taken
    assign adv           = !v_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;

    // Zero canvas is treated as one
    assign cw_eff = (cw_reg == '0) ? 16'd1 : cw_reg;
    assign ch_eff = (ch_reg == '0) ? 16'd1 : ch_reg;

    // Stage 1 and 2: rotation products, then sums with aligned translation
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            wld_s[j]   = $signed(s_axis_tdata[j*XW +: XW]);
            trans_s[j] = $signed(trans_reg[j*TB +: TB]);
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef_s[k][j]    = $signed(rot_reg[k][j*CB +: CB]);
                prod_next[k][j] = coef_s[k][j] * wld_s[j];
            end
            cam_next[k] = CW'(prod_reg[k][0]) + CW'(prod_reg[k][1]) + CW'(prod_reg[k][2])
                        + (CW'(trans_s[k]) <<< vrp_pkg::COEF_FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            cam_reg  <= cam_next;
            z_reg    <= {z_reg[ZLAST-1:1], (cam_next[2] == '0)};
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // Perspective divide
    vrp_screen_div u_sdiv_x (
        .clk    (clk),
        .en     (adv),
        .num    (cam_reg[0]),
        .depth  (cam_reg[2]),
        .screen (sx)
    );

    vrp_screen_div u_sdiv_y (
        .clk    (clk),
        .en     (adv),
        .num    (cam_reg[1]),
        .depth  (cam_reg[2]),
        .screen (sy)
    );

    // Canvas to raster mapping
    vrp_raster_map u_rmap_x (
        .clk      (clk),
        .en       (adv),
        .screen   (sx),
        .canvas   (cw_eff),
        .img_size (iw_reg),
        .flip     (1'b0),
        .raster   (rx),
        .sat      (sat_x)
    );

    vrp_raster_map u_rmap_y (
        .clk      (clk),
        .en       (adv),
        .screen   (sy),
        .canvas   (ch_eff),
        .img_size (ih_reg),
        .flip     (1'b1),
        .raster   (ry),
        .sat      (sat_y)
    );

    // Result register; zero depth overrides the raster path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= z_reg[ZLAST];
            rx_reg   <= z_reg[ZLAST] ? '0 : rx;
            ry_reg   <= z_reg[ZLAST] ? '0 : ry;
            sat_reg  <= !z_reg[ZLAST] && (sat_x || sat_y);
        end
    end

    assign m_axis_tvalid = v_reg[LAT-1];
    assign m_axis_tdata  = {ry_reg, rx_reg};
    assign m_axis_tuser  = {sat_reg, zero_reg};

endmodule

[hdl/vrp_screen_div.sv]
// Pipelined restoring divider: camera coordinate over minus camera z, Q.16.
// Depends on vrp_pkg for widths and the screen magnitude limit.
module vrp_screen_div (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [vrp_pkg::CAM_W-1:0]   num,
    input  logic signed [vrp_pkg::CAM_W-1:0]   depth,
    output logic signed [vrp_pkg::S_W-1:0]     screen
);

    localparam int STEPS = vrp_pkg::SDIV_STEPS;
    localparam int R_W   = vrp_pkg::SDIV_R_W;
    localparam int CW    = vrp_pkg::CAM_W;
    localparam int IB    = vrp_pkg::SCREEN_INT_BITS;

    logic [R_W-1:0]   r_reg     [0:STEPS-1];
    logic [CW-1:0]    b_reg     [0:STEPS-1];
    logic [STEPS-1:0] ql_reg    [0:STEPS];
    logic             neg_reg   [0:STEPS];
    logic             clamp_reg [0:STEPS];

    logic [R_W-1:0]   r_next    [1:STEPS-1];
    logic             take      [1:STEPS];

    logic [CW-1:0]    a_mag;
    logic [CW-1:0]    b_mag;
    logic             neg_in;
    logic [STEPS:0]   mag_out;

    // Operand magnitudes and quotient sign; d = -depth is negative when depth > 0
    assign a_mag  = num[CW-1] ? -num : num;
    assign b_mag  = depth[CW-1] ? -depth : depth;
    assign neg_in = num[CW-1] ^ (!depth[CW-1] && (depth != '0));

    // One quotient bit per stage
    always_comb
    begin : c_step
        logic [R_W-1:0] trial;
        logic [R_W-1:0] dvs;
        for (int i = 1; i <= STEPS; i++)
        begin
            dvs     = {1'b0, b_reg[i-1]};
            trial   = {r_reg[i-1][R_W-2:0], ql_reg[i-1][STEPS-1]};
            take[i] = (trial >= dvs);
            if (i < STEPS)
            begin
                r_next[i] = take[i] ? (trial - dvs) : trial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Entry: partial remainder is the part of a above the fraction window
            r_reg[0]     <= R_W'(a_mag[CW-1:IB]);
            ql_reg[0]    <= {a_mag[IB-1:0], {vrp_pkg::SCREEN_FRAC{1'b0}}};
            b_reg[0]     <= b_mag;
            neg_reg[0]   <= neg_in;
            clamp_reg[0] <= ({{IB{1'b0}}, a_mag} >= {b_mag, {IB{1'b0}}});
            for (int i = 1; i <= STEPS; i++)
            begin
                ql_reg[i]    <= {ql_reg[i-1][STEPS-2:0], take[i]};
                neg_reg[i]   <= neg_reg[i-1];
                clamp_reg[i] <= clamp_reg[i-1];
                if (i < STEPS)
                begin
                    r_reg[i] <= r_next[i];
                    b_reg[i] <= b_reg[i-1];
                end
            end
        end
    end

    // Integer part at or above the limit: hold the clamped magnitude, keep sign
    assign mag_out = clamp_reg[STEPS] ? vrp_pkg::SCREEN_MAG_LIMIT : {1'b0, ql_reg[STEPS]};
    assign screen  = neg_reg[STEPS] ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});

endmodule

[hdl/vrp_raster_map.sv]
// Maps one screen coordinate to a saturated raster pixel index.
// Depends on vrp_pkg; offset, multiply, 16-step divide by 16 * canvas, clamp.
module vrp_raster_map (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [vrp_pkg::S_W-1:0]        screen,
    input  logic        [vrp_pkg::CANVAS_W-1:0]   canvas,
    input  logic        [vrp_pkg::IMG_W-1:0]      img_size,
    input  logic                                  flip,
    output logic signed [vrp_pkg::RASTER_W-1:0]   raster,
    output logic                                  sat
);

    localparam int STEPS = vrp_pkg::RDIV_STEPS;
    localparam int R_W   = vrp_pkg::RDIV_R_W;
    localparam int D_W   = vrp_pkg::RDIV_D_W;
    localparam int TW    = vrp_pkg::T_W;
    localparam int NW    = vrp_pkg::N_W;

    logic signed [TW-1:0] t_reg;
    logic signed [NW-1:0] n_reg;

    logic [R_W-1:0]   r_reg   [0:STEPS-1];
    logic [D_W-1:0]   d_reg   [0:STEPS-1];
    logic [STEPS-1:0] ql_reg  [0:STEPS];
    logic             neg_reg [0:STEPS];
    logic             ovf_reg [0:STEPS];
    logic [R_W-1:0]   r_next  [1:STEPS-1];
    logic             take    [1:STEPS];

    logic signed [TW-1:0]      eight_c;
    logic signed [TW-1:0]      t_next;
    logic signed [vrp_pkg::IMG_W:0] isz_s;
    logic signed [NW-1:0]      n_next;
    logic [NW-1:0]             n_mag;
    logic [D_W-1:0]            d_in;
    logic [STEPS:0]            neg_val;
    logic [STEPS-1:0]          q;

    // Offset by half the canvas; y is flipped so rows count from the top
    assign eight_c = TW'({canvas, 3'b000});
    assign t_next  = flip ? (eight_c - TW'(screen)) : (TW'(screen) + eight_c);

    // Scale by image size
    assign isz_s  = {1'b0, img_size};
    assign n_next = isz_s * t_reg;

    // Magnitude, divisor and overflow check for the divide
    assign n_mag = n_reg[NW-1] ? -n_reg : n_reg;
    assign d_in  = {canvas, 4'b0000};

    always_comb
    begin : c_step
        logic [R_W-1:0] trial;
        logic [R_W-1:0] dvs;
        for (int i = 1; i <= STEPS; i++)
        begin
            dvs     = {1'b0, d_reg[i-1]};
            trial   = {r_reg[i-1][R_W-2:0], ql_reg[i-1][STEPS-1]};
            take[i] = (trial >= dvs);
            if (i < STEPS)
            begin
                r_next[i] = take[i] ? (trial - dvs) : trial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= t_next;
            n_reg      <= n_next;
            r_reg[0]   <= n_mag[STEPS +: R_W];
            ql_reg[0]  <= n_mag[STEPS-1:0];
            d_reg[0]   <= d_in;
            neg_reg[0] <= n_reg[NW-1];
            ovf_reg[0] <= (n_mag >= {{(NW-D_W-STEPS){1'b0}}, d_in, {STEPS{1'b0}}});
            for (int i = 1; i <= STEPS; i++)
            begin
                ql_reg[i]  <= {ql_reg[i-1][STEPS-2:0], take[i]};
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                if (i < STEPS)
                begin
                    r_reg[i] <= r_next[i];
                    d_reg[i] <= d_reg[i-1];
                end
            end
        end
    end

    // Sign restore and saturation to the 16-bit raster range
    assign q       = ql_reg[STEPS];
    assign neg_val = -{1'b0, q};

    always_comb
    begin
        sat    = 1'b0;
        raster = $signed(q);
        if (ovf_reg[STEPS])
        begin
            sat    = 1'b1;
            raster = neg_reg[STEPS] ? vrp_pkg::RASTER_MIN : vrp_pkg::RASTER_MAX;
        end
        else if (neg_reg[STEPS])
        begin
            if (q > STEPS'(17'h08000))
            begin
                sat    = 1'b1;
                raster = vrp_pkg::RASTER_MIN;
            end
            else
            begin
                raster = $signed(neg_val[STEPS-1:0]);
            end
        end
        else if (q[STEPS-1])
        begin
            sat    = 1'b1;
            raster = vrp_pkg::RASTER_MAX;
        end
    end

endmodule

[hdl/vrp_checker.sv]
// Port-level checks for the projection core, attached by bind.
// Depends on the assertion macros header.
`include "vertex_to_raster_projection_core_defines.svh"

module vrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A result waiting at the output stays offered
    `VRP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A stalled result keeps its payload
    `VRP_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Input side is ready exactly when the pipeline can move
    `VRP_ASSERT_IMPL(a_ready_flow, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

    // Zero depth gives zero raster values and no saturation
    `VRP_ASSERT_IMPL(a_zero_depth, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 32'd0) && !m_axis_tuser[1])

endmodule

bind vertex_to_raster_projection_core vrp_checker u_vrp_checker (.*);
